FILE: sv/sha1h_pkg.sv
// Shared types, constants and round helpers for the SHA-1 message hasher.
package sha1h_pkg;

    typedef logic [31:0]      t_word;
    // Five 32-bit words, index 0 is a/h0 through index 4 is e/h4
    typedef logic [4:0][31:0] t_hash;

    // Input transaction payload
    typedef struct packed {
        logic [7:0] message_byte;
        logic       byte_valid;
        logic       end_of_message;
    } t_in_item;

    // Output transaction payload
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    // Top-level sequencer
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PAD,
        ST_COMP,
        ST_OUT
    } t_top_state;

    // Compression engine sequencer
    typedef enum logic [1:0] {
        CS_IDLE,
        CS_ROUND,
        CS_ADD
    } t_core_state;

    // Control from the top-level sequencer to the compression engine
    typedef struct packed {
        logic load;   // shift a completed word into the schedule line
        logic start;  // begin compressing the buffered block
        logic init;   // restore the initial chaining words
    } t_core_ctl;

    // Status from the compression engine
    typedef struct packed {
        logic busy;
        logic done;   // chaining words are updated at this edge
    } t_core_sts;

    localparam t_hash HASH_INIT = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                   32'hEFCDAB89, 32'h67452301};

    localparam t_word K_R0 = 32'h5A827999;
    localparam t_word K_R1 = 32'h6ED9EBA1;
    localparam t_word K_R2 = 32'h8F1BBCDC;
    localparam t_word K_R3 = 32'hCA62C1D6;

    localparam logic [6:0] LAST_ROUND = 7'd79;
    localparam logic [6:0] ROUND_Q1   = 7'd20;
    localparam logic [6:0] ROUND_Q2   = 7'd40;
    localparam logic [6:0] ROUND_Q3   = 7'd60;

    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam logic [5:0] LEN_POS    = 6'd56;
    localparam logic [5:0] BLOCK_LAST = 6'd63;
    localparam logic [1:0] WORD_LAST  = 2'd3;
    localparam logic [2:0] IDX_LAST   = 3'd4;

    // Round constant for a given round number
    function automatic t_word round_k(input logic [6:0] t);
        t_word k;
        if (t < ROUND_Q1) begin
            k = K_R0;
        end else if (t < ROUND_Q2) begin
            k = K_R1;
        end else if (t < ROUND_Q3) begin
            k = K_R2;
        end else begin
            k = K_R3;
        end
        return k;
    endfunction

    // Boolean function for a given round number
    function automatic t_word round_f(input logic [6:0] t, input t_word b,
                                      input t_word c, input t_word d);
        t_word f;
        if (t < ROUND_Q1) begin
            f = (b & c) | (~b & d);
        end else if (t < ROUND_Q2) begin
            f = b ^ c ^ d;
        end else if (t < ROUND_Q3) begin
            f = (b & c) | (b & d) | (c & d);
        end else begin
            f = b ^ c ^ d;
        end
        return f;
    endfunction

endpackage

FILE: sv/sha1h_round.sv
// One SHA-1 round: the shared datapath stepped 80 times per block.
module sha1h_round (
    input  logic [6:0]      i_round,
    input  sha1h_pkg::t_hash i_vars,
    input  sha1h_pkg::t_word i_w,
    output sha1h_pkg::t_hash o_vars
);

    sha1h_pkg::t_word w_a, w_b, w_c, w_d, w_e;
    sha1h_pkg::t_word w_f, w_k, w_tmp;

    assign w_a = i_vars[0];
    assign w_b = i_vars[1];
    assign w_c = i_vars[2];
    assign w_d = i_vars[3];
    assign w_e = i_vars[4];

    // Round function and constant picked by round quarter
    assign w_f = sha1h_pkg::round_f(i_round, w_b, w_c, w_d);
    assign w_k = sha1h_pkg::round_k(i_round);

    // rotl(a,5) + f + e + k + w, modulo 2^32
    assign w_tmp = {w_a[26:0], w_a[31:27]} + w_f + w_e + w_k + i_w;

    // Rotate the working words
    assign o_vars[0] = w_tmp;
    assign o_vars[1] = w_a;
    assign o_vars[2] = {w_b[1:0], w_b[31:2]};
    assign o_vars[3] = w_c;
    assign o_vars[4] = w_d;

endmodule

FILE: sv/sha1h_core.sv
// Compression engine: schedule shift line, working words and chaining words.
module sha1h_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sha1h_pkg::t_core_ctl i_ctl,
    input  sha1h_pkg::t_word     i_word,
    output sha1h_pkg::t_core_sts o_sts,
    output sha1h_pkg::t_hash     o_hash
);

    sha1h_pkg::t_core_state r_state, n_state;
    logic [6:0]             r_round;
    sha1h_pkg::t_word       r_w [16];
    sha1h_pkg::t_hash       r_vars;
    sha1h_pkg::t_hash       r_hash;
    sha1h_pkg::t_hash       w_vars_next;
    sha1h_pkg::t_word       w_expand;

    // Shared round datapath
    sha1h_round u_round (
        .i_round (r_round),
        .i_vars  (r_vars),
        .i_w     (r_w[0]),
        .o_vars  (w_vars_next)
    );

    // Next schedule word from fixed taps of the line
    always_comb begin
        w_expand = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
        w_expand = {w_expand[30:0], w_expand[31]};
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sha1h_pkg::CS_IDLE: begin
                if (i_ctl.start) n_state = sha1h_pkg::CS_ROUND;
            end
            sha1h_pkg::CS_ROUND: begin
                if (r_round == sha1h_pkg::LAST_ROUND) n_state = sha1h_pkg::CS_ADD;
            end
            sha1h_pkg::CS_ADD: begin
                n_state = sha1h_pkg::CS_IDLE;
            end
            default: n_state = sha1h_pkg::CS_IDLE;
        endcase
    end

    // Status outputs
    always_comb begin
        o_sts.busy = (r_state != sha1h_pkg::CS_IDLE);
        o_sts.done = (r_state == sha1h_pkg::CS_ADD);
    end

    assign o_hash = r_hash;

    // Control state and chaining words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sha1h_pkg::CS_IDLE;
            r_round <= '0;
            r_hash  <= sha1h_pkg::HASH_INIT;
        end else begin
            r_state <= n_state;
            if (r_state == sha1h_pkg::CS_ROUND) begin
                r_round <= r_round + 7'd1;
            end else begin
                r_round <= '0;
            end
            if (i_ctl.init) begin
                r_hash <= sha1h_pkg::HASH_INIT;
            end else if (r_state == sha1h_pkg::CS_ADD) begin
                for (int i = 0; i < 5; i++) begin
                    r_hash[i] <= r_hash[i] + r_vars[i];
                end
            end
        end
    end

    // Schedule line: words shift in during loading, expand during rounds
    always_ff @(posedge i_clk) begin
        if (i_ctl.load || r_state == sha1h_pkg::CS_ROUND) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i + 1];
            end
            r_w[15] <= i_ctl.load ? i_word : w_expand;
        end
    end

    // Working words
    always_ff @(posedge i_clk) begin
        if (i_ctl.start && r_state == sha1h_pkg::CS_IDLE) begin
            r_vars <= r_hash;
        end else if (r_state == sha1h_pkg::CS_ROUND) begin
            r_vars <= w_vars_next;
        end
    end

endmodule

FILE: sv/sha1_message_hasher.sv
// Top level: byte intake, padding sequencer and digest output of the SHA-1 hasher.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+---------------------------------
//  in      | to block  | i_in_valid / o_in_stall  | i_in  : byte, byte flag, end flag
//  out     | from block| o_out_valid / i_out_stall| o_out : digest word, index, last
//
// A transaction that neither completes a 64-byte block nor ends the message leaves the input open.
// One that completes a block holds the input stalled while the
// round unit steps 80 rounds and adds into the chaining words.
// An end-of-message transaction pushes 9 to 72 padding bytes, one per cycle,
// with one or two compressions in between, then offers five digest words.
// Reset is synchronous; no memory needs clearing.
// Digest words hold while i_out_stall is high; input stays stalled until h4 leaves.
module sha1_message_hasher (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  sha1h_pkg::t_in_item  i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output sha1h_pkg::t_out_item o_out
);

    sha1h_pkg::t_top_state r_state, n_state;
    logic [63:0]           r_count;
    logic [63:0]           r_bits;
    logic [23:0]           r_acc;
    logic                  r_padding;
    logic                  r_mark_done;
    logic                  r_len_phase;
    logic [2:0]            r_idx;

    logic                  w_in_acc;
    logic                  w_out_acc;
    logic                  w_push_en;
    logic [7:0]            w_push_byte;
    logic                  w_block_full;
    logic                  w_len_now;
    logic [63:0]           w_len_sh;
    logic                  w_finish;

    sha1h_pkg::t_core_ctl  w_ctl;
    sha1h_pkg::t_core_sts  w_sts;
    sha1h_pkg::t_hash      w_hash;

    sha1h_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_word  ({r_acc, w_push_byte}),
        .o_sts   (w_sts),
        .o_hash  (w_hash)
    );

    assign w_in_acc  = i_in_valid && !o_in_stall;
    assign w_out_acc = o_out_valid && !i_out_stall;
    assign w_finish  = w_out_acc && (r_idx == sha1h_pkg::IDX_LAST);

    // Length byte for the current position in the last eight bytes
    assign w_len_sh  = r_bits << {r_count[2:0], 3'b000};
    assign w_len_now = r_mark_done && (r_len_phase || r_count[5:0] == sha1h_pkg::LEN_POS);

    // Byte pushed into the block this cycle
    always_comb begin
        w_push_en   = 1'b0;
        w_push_byte = i_in.message_byte;
        unique case (r_state)
            sha1h_pkg::ST_IDLE: begin
                w_push_en = w_in_acc && i_in.byte_valid;
            end
            sha1h_pkg::ST_PAD: begin
                w_push_en = 1'b1;
                if (!r_mark_done) begin
                    w_push_byte = sha1h_pkg::PAD_MARK;
                end else if (w_len_now) begin
                    w_push_byte = w_len_sh[63:56];
                end else begin
                    w_push_byte = 8'h00;
                end
            end
            sha1h_pkg::ST_COMP, sha1h_pkg::ST_OUT: begin
                w_push_en = 1'b0;
            end
            default: w_push_en = 1'b0;
        endcase
    end

    assign w_block_full = w_push_en && (r_count[5:0] == sha1h_pkg::BLOCK_LAST);

    // Engine control
    always_comb begin
        w_ctl.load  = w_push_en && (r_count[1:0] == sha1h_pkg::WORD_LAST);
        w_ctl.start = w_block_full;
        w_ctl.init  = w_finish;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sha1h_pkg::ST_IDLE: begin
                if (w_block_full) begin
                    n_state = sha1h_pkg::ST_COMP;
                end else if (w_in_acc && i_in.end_of_message) begin
                    n_state = sha1h_pkg::ST_PAD;
                end
            end
            sha1h_pkg::ST_PAD: begin
                if (w_block_full) n_state = sha1h_pkg::ST_COMP;
            end
            sha1h_pkg::ST_COMP: begin
                if (w_sts.done) begin
                    priority if (r_len_phase) begin
                        n_state = sha1h_pkg::ST_OUT;
                    end else if (r_padding) begin
                        n_state = sha1h_pkg::ST_PAD;
                    end else begin
                        n_state = sha1h_pkg::ST_IDLE;
                    end
                end
            end
            sha1h_pkg::ST_OUT: begin
                if (w_finish) n_state = sha1h_pkg::ST_IDLE;
            end
            default: n_state = sha1h_pkg::ST_IDLE;
        endcase
    end

    // Handshake and payload outputs
    always_comb begin
        o_in_stall        = (r_state != sha1h_pkg::ST_IDLE);
        o_out_valid       = (r_state == sha1h_pkg::ST_OUT);
        o_out.digest_word = w_hash[r_idx];
        o_out.word_index  = r_idx;
        o_out.last_word   = (r_idx == sha1h_pkg::IDX_LAST);
    end

    // Control state, byte count and padding flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sha1h_pkg::ST_IDLE;
            r_count     <= '0;
            r_padding   <= 1'b0;
            r_mark_done <= 1'b0;
            r_len_phase <= 1'b0;
            r_idx       <= '0;
        end else begin
            r_state <= n_state;
            if (w_push_en) begin
                r_count <= r_count + 64'd1;
            end
            if (r_state == sha1h_pkg::ST_IDLE && w_in_acc && i_in.end_of_message) begin
                r_padding <= 1'b1;
            end
            if (r_state == sha1h_pkg::ST_PAD) begin
                if (!r_mark_done) begin
                    r_mark_done <= 1'b1;
                end else if (w_len_now) begin
                    r_len_phase <= 1'b1;
                end
            end
            if (w_finish) begin
                r_idx       <= '0;
                r_count     <= '0;
                r_padding   <= 1'b0;
                r_mark_done <= 1'b0;
                r_len_phase <= 1'b0;
            end else if (w_out_acc) begin
                r_idx <= r_idx + 3'd1;
            end
        end
    end

    // Partial word and latched bit length
    always_ff @(posedge i_clk) begin
        if (w_push_en) begin
            r_acc <= {r_acc[15:0], w_push_byte};
        end
        if (r_state == sha1h_pkg::ST_PAD && !r_mark_done) begin
            r_bits <= r_count << 3;
        end
    end

`ifndef ASSERT_OFF
    // Digest words are only offered while intake is held off
    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("digest offered while input open");

    // Length bytes only occupy the last eight bytes of a block
    a_len_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len_phase |-> (r_count[5:3] == 3'd7 || r_count[5:0] == 6'd0))
        else $error("length phase outside block tail");

    // The engine only finishes while the sequencer waits on it
    a_done_in_comp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.done |-> (r_state == sha1h_pkg::ST_COMP))
        else $error("compression finished outside wait state");

    // Taking the last digest word returns to an empty message
    a_finish_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_finish |=> (r_count == 64'd0 && !r_padding && r_state == sha1h_pkg::ST_IDLE))
        else $error("state not cleared after digest");

    // No new block starts while the engine is still running
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.busy |-> !w_ctl.start)
        else $error("block started while engine busy");
`endif

endmodule
